// ----- hdl/mid_side_stem_crossfade_unit_macros.svh -----
// Assertion macros shared by the mid/side stem crossfade modules.
`ifndef MID_SIDE_STEM_CROSSFADE_UNIT_MACROS_SVH
`define MID_SIDE_STEM_CROSSFADE_UNIT_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define MSSC_ASSERT_SAME(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mssc assertion failed");

// The consequent holds in the cycle after the antecedent.
`define MSSC_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mssc assertion failed");

`endif

// ----- hdl/mssc_pkg.sv -----
// Types and constants shared by the mid/side stem crossfade modules.
package mssc_pkg;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_LEN_W  = 13;
  localparam int CFG_INC_W  = 16;

  localparam logic [CFG_IDX_W-1:0] REG_FRAMES_PER_BLOCK = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_INCREMENT   = 1'b1;

  localparam logic [CFG_LEN_W-1:0] FRAMES_PER_BLOCK_RESET = 13'd512;
  localparam logic [CFG_INC_W-1:0] RAMP_INCREMENT_RESET   = 16'd64;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_MUL4,
    ST_FIN
  } mssc_state_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_VOCAL_L,
    OP_VOCAL_R,
    OP_INSTR_L,
    OP_INSTR_R
  } mssc_op_t;

  typedef struct packed {
    logic     load;
    mssc_op_t op;
    logic     finish;
  } mssc_cmd_t;

endpackage

// ----- hdl/mssc_if.sv -----
// Stream interfaces for input frames and processed result frames.
interface mssc_frame_if #(parameter int SAMPLE_BITS = 24) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_in;
  logic signed [SAMPLE_BITS-1:0] right_in;
  logic                          vocal_on;
  logic                          instrumental_on;

  modport source (output valid, output left_in, output right_in, output vocal_on,
                  output instrumental_on, input ready);
  modport sink (input valid, input left_in, input right_in, input vocal_on,
                input instrumental_on, output ready);
endinterface

interface mssc_result_if #(parameter int SAMPLE_BITS = 24) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_out;
  logic signed [SAMPLE_BITS-1:0] right_out;
  logic                          block_end;

  modport source (output valid, output left_out, output right_out, output block_end,
                  input ready);
  modport sink (input valid, input left_out, input right_out, input block_end,
                output ready);
endinterface

// ----- hdl/mssc_ctrl.sv -----
// Sequencer that steps one frame through the shared multiplier and owns the handshakes.
`include "mid_side_stem_crossfade_unit_macros.svh"

module mssc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output mssc_pkg::mssc_cmd_t cmd
);
  import mssc_pkg::*;

  mssc_state_t state;
  mssc_state_t state_next;
  logic        out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd.load   = 1'b0;
    cmd.op     = OP_NONE;
    cmd.finish = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_MUL1;
        end
      end
      ST_MUL1: begin
        cmd.op     = OP_VOCAL_L;
        state_next = ST_MUL2;
      end
      ST_MUL2: begin
        cmd.op     = OP_VOCAL_R;
        state_next = ST_MUL3;
      end
      ST_MUL3: begin
        cmd.op     = OP_INSTR_L;
        state_next = ST_MUL4;
      end
      ST_MUL4: begin
        cmd.op     = OP_INSTR_R;
        state_next = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid || out_ready) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    out_valid_next = cmd.finish ? 1'b1 : (out_ready ? 1'b0 : out_valid);
  end

  `MSSC_ASSERT_NEXT(a_finish_shows_result, cmd.finish, out_valid)
  `MSSC_ASSERT_NEXT(a_pending_result_holds, state == ST_FIN && out_valid && !out_ready, state == ST_FIN)
  `MSSC_ASSERT_NEXT(a_load_starts_vocal, cmd.load, cmd.op == OP_VOCAL_L)

endmodule

// ----- hdl/mssc_dp.sv -----
// Datapath: configuration, gain ramps, block position and the shared blend multiplier.
`include "mid_side_stem_crossfade_unit_macros.svh"

module mssc_dp #(
  parameter int SAMPLE_BITS      = 24,
  parameter int GAIN_FRAC_BITS   = 15,
  parameter int MAX_BLOCK_FRAMES = 4096
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [mssc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mssc_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  mssc_pkg::mssc_cmd_t                 cmd,
  input  logic signed [SAMPLE_BITS-1:0]       left_in,
  input  logic signed [SAMPLE_BITS-1:0]       right_in,
  input  logic                                vocal_on,
  input  logic                                instrumental_on,
  output logic signed [SAMPLE_BITS-1:0]       left_out,
  output logic signed [SAMPLE_BITS-1:0]       right_out,
  output logic                                block_end
);
  import mssc_pkg::*;

  localparam int AW    = SAMPLE_BITS + 3;
  localparam int GW    = GAIN_FRAC_BITS + 1;
  localparam int PW    = AW + GW + 1;
  localparam int SHIFT = GAIN_FRAC_BITS + 1;
  localparam int RW    = ((GW > CFG_INC_W) ? GW : CFG_INC_W) + 1;
  localparam int POS_W = (MAX_BLOCK_FRAMES > 1) ? $clog2(MAX_BLOCK_FRAMES) : 1;
  localparam int LB    = $clog2(MAX_BLOCK_FRAMES + 1);
  localparam int CW    = ((LB > CFG_LEN_W) ? LB : CFG_LEN_W) + 1;

  localparam logic [GW-1:0]        GAIN_ONE   = {1'b1, {GAIN_FRAC_BITS{1'b0}}};
  localparam logic [CW-1:0]        LEN_MAX    = CW'(MAX_BLOCK_FRAMES);
  localparam logic signed [PW-1:0] ROUND_HALF = $signed({{(AW + 1){1'b0}}, GAIN_ONE});
  localparam logic signed [AW-1:0] SAT_MAX    = {4'b0000, {(SAMPLE_BITS - 1){1'b1}}};
  localparam logic signed [AW-1:0] SAT_MIN    = {4'b1111, {(SAMPLE_BITS - 1){1'b0}}};

  logic [CFG_LEN_W-1:0]   frames_per_block;
  logic [CFG_INC_W-1:0]   ramp_increment;
  logic [GW-1:0]          vocal_gain;
  logic [GW-1:0]          instrumental_gain;
  logic                   vocal_target;
  logic                   instrumental_target;
  logic [POS_W-1:0]       frame_position;
  logic                   last_frame;
  logic signed [AW-1:0]   left;
  logic signed [AW-1:0]   right;
  logic signed [AW-1:0]   left_mix;
  logic signed [AW-1:0]   right_mix;
  logic signed [AW-1:0]   left_res;
  logic signed [PW-1:0]   prod;

  logic                   vocal_target_next;
  logic                   instrumental_target_next;
  logic [CW-1:0]          len_eff;
  logic                   last_next;
  logic signed [AW-1:0]   mul_a;
  logic [GW-1:0]          mul_g;
  logic signed [PW-1:0]   prod_next;
  logic signed [PW-1:0]   rounded;
  logic signed [AW-1:0]   rnd;

  function automatic logic [GW-1:0] ramp_gain(input logic [GW-1:0] g, input logic tgt,
                                               input logic [CFG_INC_W-1:0] inc);
    logic [RW-1:0] up;
    up = RW'(g) + RW'(inc);
    if (tgt) begin
      ramp_gain = (up > RW'(GAIN_ONE)) ? GAIN_ONE : up[GW-1:0];
    end else begin
      ramp_gain = (RW'(g) > RW'(inc)) ? GW'(RW'(g) - RW'(inc)) : '0;
    end
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] saturate(input logic signed [AW-1:0] v);
    logic signed [AW-1:0] c;
    c = v;
    if (v > SAT_MAX) begin
      c = SAT_MAX;
    end else if (v < SAT_MIN) begin
      c = SAT_MIN;
    end
    saturate = c[SAMPLE_BITS-1:0];
  endfunction

  always_comb begin
    vocal_target_next        = (frame_position == '0) ? vocal_on : vocal_target;
    instrumental_target_next = (frame_position == '0) ? instrumental_on : instrumental_target;
    priority if (frames_per_block == '0) begin
      len_eff = CW'(1);
    end else if (CW'(frames_per_block) > LEN_MAX) begin
      len_eff = LEN_MAX;
    end else begin
      len_eff = CW'(frames_per_block);
    end
    last_next = (CW'(frame_position) + CW'(1)) >= len_eff;
  end

  always_comb begin
    unique case (cmd.op)
      OP_VOCAL_L: begin
        mul_a = right - left;
        mul_g = vocal_gain;
      end
      OP_VOCAL_R: begin
        mul_a = left - right;
        mul_g = vocal_gain;
      end
      OP_INSTR_L: begin
        mul_a = (left - right) - (left_mix <<< 1);
        mul_g = instrumental_gain;
      end
      OP_INSTR_R: begin
        mul_a = (right - left) - (right_mix <<< 1);
        mul_g = instrumental_gain;
      end
      default: begin
        mul_a = '0;
        mul_g = '0;
      end
    endcase
    prod_next = mul_a * $signed({1'b0, mul_g});
    rounded   = (prod + ROUND_HALF) >>> SHIFT;
    rnd       = rounded[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_per_block    <= FRAMES_PER_BLOCK_RESET;
      ramp_increment      <= RAMP_INCREMENT_RESET;
      vocal_gain          <= '0;
      instrumental_gain   <= '0;
      vocal_target        <= 1'b0;
      instrumental_target <= 1'b0;
      frame_position      <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_FRAMES_PER_BLOCK: frames_per_block <= cfg_data[CFG_LEN_W-1:0];
          REG_RAMP_INCREMENT:   ramp_increment   <= cfg_data[CFG_INC_W-1:0];
          default: ;
        endcase
      end
      if (cmd.load) begin
        vocal_target        <= vocal_target_next;
        instrumental_target <= instrumental_target_next;
        vocal_gain          <= ramp_gain(vocal_gain, vocal_target_next, ramp_increment);
        instrumental_gain   <= ramp_gain(instrumental_gain, instrumental_target_next,
                                         ramp_increment);
      end
      if (cmd.finish) begin
        if (last_frame) begin
          vocal_gain        <= vocal_target ? GAIN_ONE : '0;
          instrumental_gain <= instrumental_target ? GAIN_ONE : '0;
          frame_position    <= '0;
        end else begin
          frame_position    <= frame_position + POS_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op != OP_NONE) begin
      prod <= prod_next;
    end
    if (cmd.load) begin
      left       <= AW'(left_in);
      right      <= AW'(right_in);
      last_frame <= last_next;
    end
    unique case (cmd.op)
      OP_VOCAL_R: left_mix  <= left + rnd;
      OP_INSTR_L: right_mix <= right + rnd;
      OP_INSTR_R: left_res  <= left_mix + rnd;
      default: ;
    endcase
    if (cmd.finish) begin
      left_out  <= saturate(left_res);
      right_out <= saturate(right_mix + rnd);
      block_end <= last_frame;
    end
  end

  `MSSC_ASSERT_SAME(a_gain_range, 1'b1, vocal_gain <= GAIN_ONE && instrumental_gain <= GAIN_ONE)
  `MSSC_ASSERT_NEXT(a_block_wrap, cmd.finish && last_frame, frame_position == '0)

endmodule

// ----- hdl/mid_side_stem_crossfade_unit.sv -----
// A frame is loaded, passes through four blend products that share one multiplier and
// is written to the output; no new frame is accepted until the current one finishes.
// A pending result that is not taken holds the sequencer before it writes the output.
// Reset clears gains, targets and block position and loads 512 frames and step 64.
// Top level of the mid/side stem crossfade unit.
module mid_side_stem_crossfade_unit #(
  parameter int SAMPLE_BITS      = 24,
  parameter int GAIN_FRAC_BITS   = 15,
  parameter int MAX_BLOCK_FRAMES = 4096
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [mssc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mssc_pkg::CFG_DATA_W-1:0] cfg_data,
  mssc_frame_if.sink                      frame,
  mssc_result_if.source                   result
);
  import mssc_pkg::*;

  mssc_cmd_t cmd;

  mssc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (frame.valid),
    .in_ready  (frame.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .cmd       (cmd)
  );

  mssc_dp #(
    .SAMPLE_BITS      (SAMPLE_BITS),
    .GAIN_FRAC_BITS   (GAIN_FRAC_BITS),
    .MAX_BLOCK_FRAMES (MAX_BLOCK_FRAMES)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .cmd             (cmd),
    .left_in         (frame.left_in),
    .right_in        (frame.right_in),
    .vocal_on        (frame.vocal_on),
    .instrumental_on (frame.instrumental_on),
    .left_out        (result.left_out),
    .right_out       (result.right_out),
    .block_end       (result.block_end)
  );

endmodule

// ----- test/testbench.sv -----
// Self-checking testbench for the mid/side stem crossfade unit.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import mssc_pkg::*;

  localparam int SAMPLE_BITS      = 24;
  localparam int GAIN_FRAC_BITS   = 15;
  localparam int MAX_BLOCK_FRAMES = 4096;
  localparam int GAIN_ONE         = 1 << GAIN_FRAC_BITS;
  localparam longint SAMPLE_MAX   = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
  localparam longint SAMPLE_MIN   = -SAMPLE_MAX - 1;
  localparam logic signed [SAMPLE_BITS-1:0] S_MAX = SAMPLE_BITS'(SAMPLE_MAX);
  localparam logic signed [SAMPLE_BITS-1:0] S_MIN = SAMPLE_BITS'(SAMPLE_MIN);
  localparam int WATCHDOG_LIMIT   = 4000;
  localparam int HOLDOFF_CYCLES   = 400;
  localparam int SETTLE_CYCLES    = 20;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_in;
    logic signed [SAMPLE_BITS-1:0] right_in;
    logic                          vocal_on;
    logic                          instrumental_on;
  } frame_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;
    logic                          block_end;
  } mix_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  mssc_frame_if  #(.SAMPLE_BITS(SAMPLE_BITS)) frame_ch ();
  mssc_result_if #(.SAMPLE_BITS(SAMPLE_BITS)) result_ch ();

  mid_side_stem_crossfade_unit #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .GAIN_FRAC_BITS(GAIN_FRAC_BITS),
    .MAX_BLOCK_FRAMES(MAX_BLOCK_FRAMES)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .frame(frame_ch),
    .result(result_ch)
  );

  always #4 clk = ~clk;

  logic [CFG_LEN_W-1:0] frames_per_block_q = FRAMES_PER_BLOCK_RESET;
  logic [CFG_INC_W-1:0] ramp_step_q = RAMP_INCREMENT_RESET;
  logic [15:0]          vocal_gain_q = '0;
  logic [15:0]          instr_gain_q = '0;
  logic                 vocal_target_q = 1'b0;
  logic                 instr_target_q = 1'b0;
  int unsigned          block_pos = 0;

  mix_t expected_mixes[$];
  int   mismatch_count = 0;
  int   sender_idle_pct = 0;
  int   receiver_stall_pct = 0;
  int   holdoff_left = 0;
  int   quiet_cycles = 0;

  function automatic logic [15:0] step_gain(logic [15:0] gain, logic target);
    logic [16:0] sum;
    sum = {1'b0, gain} + {1'b0, ramp_step_q};
    if (target) return (sum > GAIN_ONE) ? 16'(GAIN_ONE) : sum[15:0];
    return (gain > ramp_step_q) ? gain - ramp_step_q : 16'd0;
  endfunction

  function automatic longint blend_term(longint diff, logic [15:0] gain);
    longint prod;
    prod = diff * longint'({48'd0, gain}) + (longint'(1) << GAIN_FRAC_BITS);
    return prod >>> (GAIN_FRAC_BITS + 1);
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] clip_sample(longint v);
    if (v > SAMPLE_MAX) return S_MAX;
    if (v < SAMPLE_MIN) return S_MIN;
    return SAMPLE_BITS'(v);
  endfunction

  function automatic mix_t predict_crossfade(frame_t item);
    mix_t        res;
    int unsigned span;
    longint      l, r, l1, r1, l2, r2;
    span = (frames_per_block_q == 0) ? 1 :
           (frames_per_block_q > MAX_BLOCK_FRAMES) ? MAX_BLOCK_FRAMES : frames_per_block_q;
    if (block_pos == 0) begin
      vocal_target_q = item.vocal_on;
      instr_target_q = item.instrumental_on;
    end
    vocal_gain_q = step_gain(vocal_gain_q, vocal_target_q);
    instr_gain_q = step_gain(instr_gain_q, instr_target_q);
    l = longint'(item.left_in);
    r = longint'(item.right_in);
    l1 = l + blend_term(r - l, vocal_gain_q);
    r1 = r + blend_term(l - r, vocal_gain_q);
    l2 = l1 + blend_term((l - r) - 2 * l1, instr_gain_q);
    r2 = r1 + blend_term((r - l) - 2 * r1, instr_gain_q);
    res.left_out = clip_sample(l2);
    res.right_out = clip_sample(r2);
    res.block_end = (block_pos + 1 >= span);
    if (res.block_end) begin
      vocal_gain_q = vocal_target_q ? 16'(GAIN_ONE) : 16'd0;
      instr_gain_q = instr_target_q ? 16'(GAIN_ONE) : 16'd0;
      block_pos = 0;
    end else begin
      block_pos++;
    end
    return res;
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] random_sample();
    case ($urandom_range(7))
      0: return S_MAX;
      1: return S_MIN;
      2: return SAMPLE_BITS'(int'($urandom_range(255)) - 128);
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  function automatic frame_t random_frame();
    frame_t item;
    item.left_in = random_sample();
    item.right_in = random_sample();
    item.vocal_on = $urandom_range(1);
    item.instrumental_on = $urandom_range(1);
    return item;
  endfunction

  task automatic send_frame(input frame_t item);
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      frame_ch.valid <= 1'b0;
      @(negedge clk);
    end
    frame_ch.valid <= 1'b1;
    frame_ch.left_in <= item.left_in;
    frame_ch.right_in <= item.right_in;
    frame_ch.vocal_on <= item.vocal_on;
    frame_ch.instrumental_on <= item.instrumental_on;
    do @(posedge clk); while (!frame_ch.ready);
    expected_mixes.push_back(predict_crossfade(item));
  endtask

  task automatic send_random(input int count);
    repeat (count) send_frame(random_frame());
  endtask

  task automatic drain();
    @(negedge clk);
    frame_ch.valid <= 1'b0;
    while (expected_mixes.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_FRAMES_PER_BLOCK: frames_per_block_q = value[CFG_LEN_W-1:0];
      REG_RAMP_INCREMENT:   ramp_step_q = value[CFG_INC_W-1:0];
      default: ;
    endcase
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] frames,
                           input logic [CFG_DATA_W-1:0] step);
    write_register(REG_FRAMES_PER_BLOCK, frames);
    write_register(REG_RAMP_INCREMENT, step);
  endtask

  task automatic set_traffic(input int sender_pct, input int receiver_pct);
    sender_idle_pct = sender_pct;
    receiver_stall_pct = receiver_pct;
  endtask

  task automatic test_reset_settings();
    frame_t item;
    for (int i = 0; i < 6; i++) begin
      item = random_frame();
      item.vocal_on = i[0];
      item.instrumental_on = i[1];
      send_frame(item);
    end
    drain();
  endtask

  task automatic test_sample_extremes();
    frame_t item;
    configure(16'd1, 16'd32768);
    for (int i = 0; i < 16; i++) begin
      case (i % 8)
        0: begin item.left_in = S_MAX; item.right_in = S_MIN; end
        1: begin item.left_in = S_MIN; item.right_in = S_MAX; end
        2: begin item.left_in = S_MAX; item.right_in = S_MAX; end
        3: begin item.left_in = S_MIN; item.right_in = S_MIN; end
        4: begin item.left_in = '0;    item.right_in = '0;    end
        5: begin item.left_in = '1;    item.right_in = 1;     end
        6: begin item.left_in = S_MAX; item.right_in = '0;    end
        default: begin item.left_in = '0; item.right_in = S_MIN; end
      endcase
      item.vocal_on = i[0] ^ i[3];
      item.instrumental_on = i[1] ^ i[3];
      send_frame(item);
    end
    drain();
  endtask

  task automatic test_block_length_limits();
    configure(16'd0, 16'hFFFF);
    send_random(10);
    drain();
    configure(16'h1FFF, 16'd8);
    send_random(30);
    drain();
    configure(16'hE003, 16'd0);
    send_random(10);
    drain();
  endtask

  task automatic test_length_change();
    configure(16'd64, 16'd1024);
    send_random(30);
    drain();
    configure(16'd5, 16'd7000);
    send_random(12);
    drain();
  endtask

  task automatic test_backpressure();
    configure(16'd4, 16'd12000);
    set_traffic(0, 0);
    holdoff_left = HOLDOFF_CYCLES;
    send_random(30);
    drain();
    send_random(30);
    drain();
  endtask

  task automatic test_random_traffic();
    int frames;
    int step;
    for (int p = 0; p < 16; p++) begin
      case (p / 4)
        0: set_traffic(0, 0);
        1: set_traffic(56, 0);
        2: set_traffic(0, 56);
        default: set_traffic(32, 32);
      endcase
      case (p % 4)
        0: begin
          frames = $urandom_range(1, 16);
          step = (32768 + frames / 2) / frames;
        end
        1: begin
          frames = $urandom_range(17, 300);
          step = $urandom_range(8, 32768);
        end
        2: begin
          frames = $urandom_range(0, 8191);
          step = $urandom_range(0, 65535);
        end
        default: begin
          frames = $urandom_range(1, 8);
          step = $urandom_range(8, 2000);
        end
      endcase
      drain();
      configure({3'($urandom), 13'(frames)}, 16'(step));
      send_random(75);
    end
    drain();
  endtask

  always @(negedge clk) begin
    if (holdoff_left != 0) begin
      result_ch.ready <= 1'b0;
      holdoff_left = holdoff_left - 1;
    end else begin
      result_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  always @(posedge clk) begin : check_mixes
    mix_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (expected_mixes.size() == 0) begin
        $error("result transfer with no expected frame pending");
        mismatch_count++;
      end else begin
        want = expected_mixes.pop_front();
        if (result_ch.left_out !== want.left_out) begin
          $error("left_out: expected %0d, got %0d", want.left_out, result_ch.left_out);
          mismatch_count++;
        end
        if (result_ch.right_out !== want.right_out) begin
          $error("right_out: expected %0d, got %0d", want.right_out, result_ch.right_out);
          mismatch_count++;
        end
        if (result_ch.block_end !== want.block_end) begin
          $error("block_end: expected %0d, got %0d", want.block_end, result_ch.block_end);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (frame_ch.valid && frame_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    frame_ch.valid = 1'b0;
    frame_ch.left_in = '0;
    frame_ch.right_in = '0;
    frame_ch.vocal_on = 1'b0;
    frame_ch.instrumental_on = 1'b0;
    result_ch.ready = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_settings();
    test_sample_extremes();
    test_block_length_limits();
    test_length_change();
    test_backpressure();
    test_random_traffic();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_mixes.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/mssc_pkg.sv
hdl/mssc_if.sv
hdl/mssc_ctrl.sv
hdl/mssc_dp.sv
hdl/mid_side_stem_crossfade_unit.sv
test/testbench.sv
